FILE: design/utt_pkg.sv
// shared types, constants and unit expansion functions for the utf-8 / utf-16 transcoder
package utt_pkg;

  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned CODE_W    = 21;

  // what the back part has to emit for one job
  typedef enum logic [1:0] {
    KIND_CODE = 2'b00,
    KIND_BAD  = 2'b01,
    KIND_EOT  = 2'b10
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic              dir;
    logic [CODE_W-1:0] code;
  } job_t;

  // index of the final unit a code point expands to
  function automatic logic [1:0] last_index(logic dir, logic [CODE_W-1:0] code);
    logic [1:0] r;
    if (!dir) begin
      r = (code > 21'h00FFFF) ? 2'd1 : 2'd0;
    end else if (code <= 21'h00007F) begin
      r = 2'd0;
    end else if (code <= 21'h0007FF) begin
      r = 2'd1;
    end else if (code <= 21'h00FFFF) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // one output unit of a code point
  function automatic logic [15:0] unit_value(logic dir, logic [CODE_W-1:0] code,
                                             logic [1:0] idx);
    logic [19:0] v;
    logic [1:0]  n;
    logic [15:0] r;
    v = 20'(code - 21'h010000);
    n = last_index(dir, code);
    r = '0;
    if (!dir) begin
      if (n == 2'd0) begin
        r = code[15:0];
      end else if (idx == 2'd0) begin
        r = {6'b110110, v[19:10]};
      end else begin
        r = {6'b110111, v[9:0]};
      end
    end else begin
      case (n)
        2'd0: r = {8'h00, code[7:0]};
        2'd1: r = (idx == 2'd0) ? {8'h00, 3'b110, code[10:6]}
                                : {8'h00, 2'b10, code[5:0]};
        2'd2: begin
          case (idx)
            2'd0:    r = {8'h00, 4'b1110, code[15:12]};
            2'd1:    r = {8'h00, 2'b10, code[11:6]};
            default: r = {8'h00, 2'b10, code[5:0]};
          endcase
        end
        default: begin
          case (idx)
            2'd0:    r = {8'h00, 5'b11110, code[20:18]};
            2'd1:    r = {8'h00, 2'b10, code[17:12]};
            2'd2:    r = {8'h00, 2'b10, code[11:6]};
            default: r = {8'h00, 2'b10, code[5:0]};
          endcase
        end
      endcase
    end
    return r;
  endfunction

endpackage

FILE: design/utt_front.sv
// front part: direction register, sequence decode and surrogate pairing
module utt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_direction_i,
  input  logic           in_valid_i,
  input  logic [15:0]    in_unit_i,
  output logic           job_push_o,
  output utt_pkg::job_t  job_o
);
  import utt_pkg::*;

  logic              dir_q;
  logic [CODE_W-1:0] partial_q, partial_d;
  logic [1:0]        remain_q, remain_d;
  logic              held_q, held_d;
  logic              emit;
  logic              bad;
  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] shifted;
  logic [7:0]        b;

  assign b       = in_unit_i[7:0];
  assign shifted = {partial_q[CODE_W-7:0], b[5:0]};

  // decode one beat
  always_comb begin
    partial_d = partial_q;
    remain_d  = remain_q;
    held_d    = held_q;
    emit      = 1'b0;
    bad       = 1'b0;
    code      = '0;
    if (!dir_q) begin
      if (remain_q == 2'd0) begin
        if (!b[7]) begin
          emit = 1'b1;
          code = CODE_W'(b[6:0]);
        end else if (b[7:5] == 3'b110) begin
          partial_d = CODE_W'(b[4:0]);
          remain_d  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          partial_d = CODE_W'(b[3:0]);
          remain_d  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          partial_d = CODE_W'(b[2:0]);
          remain_d  = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else if (remain_q == 2'd1) begin
        emit      = 1'b1;
        code      = shifted;
        partial_d = '0;
        remain_d  = 2'd0;
      end else begin
        partial_d = shifted;
        remain_d  = remain_q - 2'd1;
      end
    end else begin
      if (held_q) begin
        if (in_unit_i[15:10] != 6'b110111) begin
          bad = 1'b1;
        end else begin
          emit      = 1'b1;
          code      = {1'b0, partial_q[9:0], in_unit_i[9:0]} + 21'h010000;
          partial_d = '0;
          held_d    = 1'b0;
        end
      end else if (in_unit_i[15:10] == 6'b110110) begin
        partial_d = CODE_W'(in_unit_i[9:0]);
        held_d    = 1'b1;
      end else begin
        emit = 1'b1;
        code = CODE_W'(in_unit_i);
      end
    end
    if (bad) begin
      partial_d = '0;
      remain_d  = 2'd0;
      held_d    = 1'b0;
    end
  end

  // job handed to the queue
  always_comb begin
    job_o.dir  = dir_q;
    job_o.code = bad ? '0 : code;
    if (bad) begin
      job_o.kind = KIND_BAD;
    end else if (code == '0) begin
      job_o.kind = KIND_EOT;
    end else begin
      job_o.kind = KIND_CODE;
    end
  end

  assign job_push_o = in_valid_i && (emit || bad);

  // direction and pending sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= 1'b0;
      partial_q <= '0;
      remain_q  <= 2'd0;
      held_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      dir_q     <= cfg_direction_i;
      partial_q <= '0;
      remain_q  <= 2'd0;
      held_q    <= 1'b0;
    end else if (in_valid_i) begin
      partial_q <= partial_d;
      remain_q  <= remain_d;
      held_q    <= held_d;
    end
  end

endmodule

FILE: design/utt_job_fifo.sv
// short job queue between the front and the back part
module utt_job_fifo #(
  parameter int unsigned Depth = utt_pkg::JOB_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  utt_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output utt_pkg::job_t  job_o
);
  import utt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("job queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job popped from empty queue");

endmodule

FILE: design/utt_back.sv
// back part: expands one job into output units, one beat per cycle while results are taken
module utt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  utt_pkg::job_t  job_i,
  output logic           job_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [15:0]    out_unit_o,
  output logic           last_of_run_o,
  output logic           bad_input_o,
  output logic           end_of_text_o
);
  import utt_pkg::*;

  logic        out_valid_q;
  logic [15:0] unit_q;
  logic        last_q, bad_q, eot_q;
  logic [1:0]  idx_q;
  logic [1:0]  last_idx;
  logic [15:0] unit;
  logic        load;
  logic        is_last;

  // unit selection for the head job
  always_comb begin
    case (job_i.kind)
      KIND_CODE: begin
        last_idx = last_index(job_i.dir, job_i.code);
        unit     = unit_value(job_i.dir, job_i.code, idx_q);
      end
      default: begin
        last_idx = 2'd0;
        unit     = '0;
      end
    endcase
  end

  assign load      = job_valid_i && (!out_valid_q || pop_i);
  assign is_last   = (idx_q == last_idx);
  assign job_pop_o = load && is_last;

  // output register and unit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q <= unit;
      last_q <= is_last;
      bad_q  <= (job_i.kind == KIND_BAD);
      eot_q  <= (job_i.kind == KIND_EOT);
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_unit_o    = unit_q;
  assign last_of_run_o = last_q;
  assign bad_input_o   = bad_q;
  assign end_of_text_o = eot_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(bad_q && eot_q)) else $error("bad and end flags together");

  a_flag_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (bad_q || eot_q)) |-> (last_q && unit_q == '0))
    else $error("flagged result not a single zero unit");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q <= last_idx) else $error("unit index past job end");

endmodule

FILE: design/utf8_utf16_stream_transcoder.sv
// top level of the utf-8 / utf-16 stream transcoder
//
// Input channel: push/full. One beat carries in_unit_i, a UTF-8 byte in bits
// 7..0 (direction 0) or a UTF-16 unit (direction 1).
// Result channel: empty/pop. The oldest result sits on out_unit_o and its flags
// while empty is low; pop takes it. last_of_run_o marks the final result of a
// code point, bad_input_o a malformed sequence, end_of_text_o a zero code point.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_direction_i; ready is always
// high, and a write clears any pending sequence. Write it only when idle.
// Flow: with the back idle, the job of a completing input beat is written into
// the job queue at the accepting edge, then loaded into the output register.
// Throughput: the expansion unit gives one result per cycle while results are
// taken; an item causes 1 to 4 results, and items that only extend a sequence
// cause none. The front takes a beat every cycle while the job queue has room.
// Reset: direction returns to UTF-8 input, all pending state and queued
// results are dropped.
// Receiver stall: the held result stays, the back stops, the job queue fills,
// then full rises and the input stalls.
module utf8_utf16_stream_transcoder #(
  parameter int unsigned JobDepth = utt_pkg::JOB_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_direction_i,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_unit_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_unit_o,
  output logic        last_of_run_o,
  output logic        bad_input_o,
  output logic        end_of_text_o
);
  import utt_pkg::*;

  logic  in_accept;
  logic  job_push;
  job_t  job_in;
  logic  job_empty;
  logic  job_pop;
  job_t  job_head;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = push && !full;

  // decode front
  utt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_direction_i (cfg_direction_i),
    .in_valid_i      (in_accept),
    .in_unit_i       (in_unit_i),
    .job_push_o      (job_push),
    .job_o           (job_in)
  );

  // job queue
  utt_job_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .job_o   (job_head)
  );

  // expansion back
  utt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!job_empty),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_unit_o    (out_unit_o),
    .last_of_run_o (last_of_run_o),
    .bad_input_o   (bad_input_o),
    .end_of_text_o (end_of_text_o)
  );

endmodule
